@@ hdl/smalu_pkg.sv @@
package smalu_pkg;

   // Word layout: sign in the top bit, magnitude below it.
   localparam int WORD_W = 32;
   localparam int MAG_W = WORD_W - 1;
   localparam int PROD_W = 2 * MAG_W;
   localparam int FRACTION_BITS_DEFAULT = 15;

   localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

   // Operation codes carried on the request tuser.
   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_MUL = 2'd1,
      OP_DIV = 2'd2,
      OP_VEC = 2'd3
   } op_type;

   // Control of the shared divide and square root unit.
   typedef struct packed {
      logic start;
      logic sqrt_mode;
   } dsq_ctrl_type;

endpackage

@@ hdl/smalu_serial_mul.sv @@
module smalu_serial_mul
   import smalu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MAG_W-1:0]  multiplicand,
   input  logic [MAG_W-1:0]  multiplier,
   output logic [PROD_W-1:0] product,
   output logic              done
);

   localparam int CNT_W = $clog2(MAG_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAG_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MAG_W-1:0]  mcand_ff, mcand_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [MAG_W:0]    partial_sum;

   // One multiplier bit per cycle: add the multiplicand into the upper half
   // when the low bit is set, then shift the whole product right by one.
   always_comb begin
      partial_sum = {1'b0, prod_ff[PROD_W-1:MAG_W]}
                  + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      mcand_in = mcand_ff;
      prod_in = prod_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         mcand_in = multiplicand;
         prod_in = {{MAG_W{1'b0}}, multiplier};
      end else if (busy_ff) begin
         prod_in = {partial_sum, prod_ff[MAG_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      mcand_ff <= mcand_in;
      prod_ff <= prod_in;
   end

   assign product = prod_ff;
   assign done = done_ff;

endmodule

@@ hdl/smalu_div_sqrt.sv @@
module smalu_div_sqrt
   import smalu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  dsq_ctrl_type        ctrl,
   input  logic [2*WORD_W-1:0] source,
   input  logic [MAG_W-1:0]    rem_init,
   input  logic [MAG_W-1:0]    divisor,
   output logic [WORD_W-1:0]   outcome,
   output logic                done
);

   localparam int CNT_W = $clog2(WORD_W);
   localparam int REM_W = WORD_W + 2;
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_W - 1);
   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(WORD_W - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                sqrt_ff, sqrt_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [2*WORD_W-1:0] src_ff, src_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [MAG_W-1:0]    den_ff, den_in;
   logic [WORD_W-1:0]   res_ff, res_in;
   logic [REM_W:0]      shifted;
   logic [REM_W:0]      trial;
   logic                fits;
   logic [REM_W:0]      diff;

   // One result bit per cycle. Division brings down one dividend bit and
   // tries the divisor; square root brings down two radicand bits and tries
   // four times the partial root plus one.
   always_comb begin
      if (sqrt_ff) begin
         shifted = {rem_ff[REM_W-2:0], src_ff[2*WORD_W-1 -: 2]};
         trial = {1'b0, res_ff, 2'b01};
      end else begin
         shifted = {rem_ff, src_ff[2*WORD_W-1]};
         trial = {{(REM_W+1-MAG_W){1'b0}}, den_ff};
      end
      fits = (shifted >= trial);
      diff = shifted - trial;

      busy_in = busy_ff;
      done_in = 1'b0;
      sqrt_in = sqrt_ff;
      cnt_in = cnt_ff;
      src_in = src_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      res_in = res_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         sqrt_in = ctrl.sqrt_mode;
         cnt_in = '0;
         src_in = source;
         rem_in = {{(REM_W-MAG_W){1'b0}}, rem_init};
         den_in = divisor;
         res_in = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
         res_in = {res_ff[WORD_W-2:0], fits};
         src_in = sqrt_ff ? {src_ff[2*WORD_W-3:0], 2'b00} : {src_ff[2*WORD_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == (sqrt_ff ? SQRT_LAST : DIV_LAST)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      sqrt_ff <= sqrt_in;
      src_ff <= src_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      res_ff <= res_in;
   end

   assign outcome = res_ff;
   assign done = done_ff;

endmodule

@@ hdl/sign_magnitude_fixed_point_alu.sv @@
// Sign-magnitude fixed-point ALU on 32-bit words (sign in bit 31, magnitude
// in bits 30..0 with FRACTION_BITS fraction bits, saturated at 0x7fffffff).
// A request word carries the opcode on req_tuser and the two operands on
// req_tdata; every request produces exactly one response word on rsp_tdata.
// The block works on one request at a time: req_tready is high only while
// it is idle, and it rises again as soon as the result is in the output
// register, so a new request overlaps a response still waiting downstream.
// Path from acceptance to the response word in the output register:
//   add        one 32-bit add and compare, then the output register
//   multiply   shift-add multiplier, one multiplier bit a cycle
//   divide     restoring divider, one quotient bit a cycle, or straight to
//              the output when the divisor is zero or the quotient saturates
//   vector     both squares in parallel serial multipliers, then the
//              shared unit resolves one root bit per cycle over 32 steps
// rsp_tvalid rises with that register, and the next request can be taken in
// that same cycle.
// The response holds while rsp_tready is low; a finished result then waits
// and no new request is taken.
// Reset clears the controllers and the response valid; the data registers are not reset.
module sign_magnitude_fixed_point_alu
   import smalu_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2*WORD_W-1:0] req_tdata,   // operand_a [31:0], operand_b [63:32]
   input  logic [1:0]          req_tuser,   // operation [1:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [WORD_W-1:0]   rsp_tdata    // result [31:0]
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_MUL,
      S_DSQ,
      S_OUT
   } state_type;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [WORD_W-1:0]   a_ff, a_in;
   logic [WORD_W-1:0]   b_ff, b_in;
   logic                sign_ff, sign_in;
   logic [WORD_W-1:0]   final_ff, final_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   rsp_data_ff, rsp_data_in;

   op_type              req_op;
   logic [MAG_W-1:0]    req_ma, req_mb;
   logic [PROD_W-1:0]   req_num;
   logic                accept;
   logic                div_sat;

   logic                mul_start;
   logic [MAG_W-1:0]    mul_a_mcand, mul_a_mplier, mul_b_mcand, mul_b_mplier;
   logic [PROD_W-1:0]   prod_a, prod_b;
   logic                mul_a_done, mul_b_done;
   logic [PROD_W-1:0]   prod_shifted;
   logic [PROD_W:0]     square_sum;

   dsq_ctrl_type        dsq_ctrl;
   logic [2*WORD_W-1:0] dsq_source;
   logic [MAG_W-1:0]    dsq_rem_init, dsq_divisor;
   logic [WORD_W-1:0]   dsq_outcome;
   logic                dsq_done;

   logic [MAG_W-1:0]    ma, mb;
   logic [MAG_W:0]      mag_sum;
   logic [MAG_W-1:0]    mag_diff;
   logic                add_sign;
   logic [MAG_W-1:0]    add_mag;

   // Request fields and the scaled dividend, ready at acceptance.
   assign req_op = op_type'(req_tuser);
   assign req_ma = req_tdata[MAG_W-1:0];
   assign req_mb = req_tdata[WORD_W+MAG_W-1:WORD_W];
   assign req_num = {{MAG_W{1'b0}}, req_ma} << FRACTION_BITS;
   assign accept = req_tvalid && (state_ff == S_IDLE);
   // The quotient exceeds the magnitude range when the upper dividend half
   // already reaches the divisor; a zero divisor lands here as well.
   assign div_sat = (req_num[PROD_W-1:MAG_W] >= req_mb);

   // Serial multipliers: one does the product or the square of operand a,
   // the other the square of operand b.
   assign mul_start = accept && ((req_op == OP_MUL) || (req_op == OP_VEC));
   assign mul_a_mcand = req_ma;
   assign mul_a_mplier = (req_op == OP_VEC) ? req_ma : req_mb;
   assign mul_b_mcand = req_mb;
   assign mul_b_mplier = req_mb;

   smalu_serial_mul u_mul_a (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (mul_a_mcand),
      .multiplier   (mul_a_mplier),
      .product      (prod_a),
      .done         (mul_a_done)
   );

   smalu_serial_mul u_mul_b (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (mul_b_mcand),
      .multiplier   (mul_b_mplier),
      .product      (prod_b),
      .done         (mul_b_done)
   );

   assign prod_shifted = prod_a >> FRACTION_BITS;
   assign square_sum = {1'b0, prod_a} + {1'b0, prod_b};

   // The shared unit starts a division straight from a request that does not
   // saturate, or a square root once both squares are in.
   always_comb begin
      dsq_ctrl.start = 1'b0;
      dsq_ctrl.sqrt_mode = 1'b0;
      dsq_source = {req_num[MAG_W-1:0], {(2*WORD_W-MAG_W){1'b0}}};
      dsq_rem_init = req_num[PROD_W-1:MAG_W];
      dsq_divisor = req_mb;
      if (state_ff == S_MUL) begin
         dsq_ctrl.start = mul_a_done && mul_b_done && (op_ff == OP_VEC);
         dsq_ctrl.sqrt_mode = 1'b1;
         dsq_source = {{(2*WORD_W-PROD_W-1){1'b0}}, square_sum};
         dsq_rem_init = '0;
      end else begin
         dsq_ctrl.start = accept && (req_op == OP_DIV) && !div_sat;
      end
   end

   smalu_div_sqrt u_div_sqrt (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (dsq_ctrl),
      .source   (dsq_source),
      .rem_init (dsq_rem_init),
      .divisor  (dsq_divisor),
      .outcome  (dsq_outcome),
      .done     (dsq_done)
   );

   // Signed add of two sign-magnitude words; a zero sum is always positive.
   always_comb begin
      ma = a_ff[MAG_W-1:0];
      mb = b_ff[MAG_W-1:0];
      mag_sum = {1'b0, ma} + {1'b0, mb};
      mag_diff = (ma >= mb) ? (ma - mb) : (mb - ma);
      if (a_ff[WORD_W-1] == b_ff[WORD_W-1]) begin
         add_mag = mag_sum[MAG_W] ? MAG_MAX : mag_sum[MAG_W-1:0];
         add_sign = a_ff[WORD_W-1] && (mag_sum != '0);
      end else begin
         add_mag = mag_diff;
         add_sign = (ma >= mb) ? (a_ff[WORD_W-1] && (mag_diff != '0)) : b_ff[WORD_W-1];
      end
   end

   // Sequencer and output register.
   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      a_in = a_ff;
      b_in = b_ff;
      sign_in = sign_ff;
      final_in = final_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_op;
               a_in = req_tdata[WORD_W-1:0];
               b_in = req_tdata[2*WORD_W-1:WORD_W];
               sign_in = req_tdata[WORD_W-1] ^ req_tdata[2*WORD_W-1];
               case (req_op)
                  OP_ADD: state_in = S_ADD;
                  OP_DIV: begin
                     if (div_sat) begin
                        final_in = {req_tdata[WORD_W-1] ^ req_tdata[2*WORD_W-1], MAG_MAX};
                        state_in = S_OUT;
                     end else begin
                        state_in = S_DSQ;
                     end
                  end
                  default: state_in = S_MUL;
               endcase
            end
         end
         S_ADD: begin
            final_in = {add_sign, add_mag};
            state_in = S_OUT;
         end
         S_MUL: begin
            if (mul_a_done && mul_b_done) begin
               if (op_ff == OP_VEC) begin
                  state_in = S_DSQ;
               end else begin
                  final_in = {sign_ff, (prod_shifted > PROD_W'(MAG_MAX)) ? MAG_MAX
                                                     : prod_shifted[MAG_W-1:0]};
                  state_in = S_OUT;
               end
            end
         end
         S_DSQ: begin
            if (dsq_done) begin
               final_in = {sign_ff, dsq_outcome[WORD_W-1] ? MAG_MAX
                                                          : dsq_outcome[MAG_W-1:0]};
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = final_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      a_ff <= a_in;
      b_ff <= b_in;
      sign_ff <= sign_in;
      final_ff <= final_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule
